// File: design/neighbor_table_with_aging_defines.svh
// Assertion macros for the neighbour table.
`ifndef NEIGHBOR_TABLE_WITH_AGING_DEFINES_SVH
`define NEIGHBOR_TABLE_WITH_AGING_DEFINES_SVH

`ifndef ASSERT_OFF
// Implication or plain property, checked on every rising edge out of reset.
`define NTA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition that must never hold.
`define NTA_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define NTA_ASSERT(lbl, prop, msg)
`define NTA_NEVER(lbl, cond, msg)
`endif

`endif

// File: design/nta_pkg.sv
package nta_pkg;

    localparam int unsigned MAX_ENTRIES_DEF = 16;

    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned LEVEL_W = 11;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned CNT_OUT_W = 5;

    localparam logic [TIME_W-1:0] AGE_TIMEOUT_RESET = 32'd120000;

    localparam logic OP_SEEN  = 1'b0;
    localparam logic OP_SWEEP = 1'b1;

    typedef enum logic [1:0] {
        STATUS_REFRESHED = 2'd0,
        STATUS_INSERTED  = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_SWEPT     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_RUN,
        FSM_DONE
    } fsm_t;

    // One neighbour record.
    typedef struct packed {
        logic [ADDR_W-1:0]         addr;
        logic signed [LEVEL_W-1:0] level;
        logic [TIME_W-1:0]         seen;
    } rec_t;

    // Control broadcast to every cell of the row.
    typedef struct packed {
        logic step;
        logic push;
    } cell_ctrl_t;

endpackage

// File: design/nta_cell.sv
module nta_cell #(
    parameter int unsigned MAX_ENTRIES = nta_pkg::MAX_ENTRIES_DEF,
    parameter int unsigned INDEX       = 0,
    localparam int unsigned CW         = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                clk,
    input  nta_pkg::cell_ctrl_t ctrl,
    input  logic [CW-1:0]       ring_len,
    input  nta_pkg::rec_t       nbr_rec,
    input  nta_pkg::rec_t       push_rec,
    output nta_pkg::rec_t       rec
);

    localparam logic [CW-1:0] POS = CW'(INDEX + 1);

    nta_pkg::rec_t rec_reg;
    nta_pkg::rec_t rec_next;

    // Cells inside the ring take from their neighbour; the last ring cell
    // takes the pushed record when push is set; cells outside the ring hold.
    always_comb
    begin
        rec_next = rec_reg;
        if (ctrl.step)
        begin
            if (POS < ring_len)
            begin
                rec_next = nbr_rec;
            end
            else if (POS == ring_len && ctrl.push)
            begin
                rec_next = push_rec;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    assign rec = rec_reg;

endmodule

// File: design/nta_row.sv
module nta_row #(
    parameter int unsigned MAX_ENTRIES = nta_pkg::MAX_ENTRIES_DEF,
    localparam int unsigned CW         = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                clk,
    input  nta_pkg::cell_ctrl_t ctrl,
    input  logic [CW-1:0]       ring_len,
    input  nta_pkg::rec_t       push_rec,
    output nta_pkg::rec_t       head_rec
);

    nta_pkg::rec_t cell_q [MAX_ENTRIES];

    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        nta_pkg::rec_t nbr;

        // The last cell has no neighbour; it only ever loads the pushed record.
        if (i == MAX_ENTRIES - 1)
        begin : g_last
            assign nbr = push_rec;
        end
        else
        begin : g_mid
            assign nbr = cell_q[i+1];
        end

        nta_cell #(
            .MAX_ENTRIES (MAX_ENTRIES),
            .INDEX       (i)
        ) u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .ring_len (ring_len),
            .nbr_rec  (nbr),
            .push_rec (push_rec),
            .rec      (cell_q[i])
        );
    end

    assign head_rec = cell_q[0];

endmodule

// File: design/neighbor_table_with_aging.sv
// Neighbour table with aging.
// An input transfer (in_valid/in_ready) carries one item: operation 0 reports
// a neighbour heard (refresh its record or append a new one), operation 1
// sweeps out every record older than age_timeout. Each item gives exactly one
// result transfer (out_valid/out_ready) with a status, the record count after
// the item and, for a sweep, the number of records removed.
// The records sit in a row of MAX_ENTRIES cells that works as a circular
// queue: each cycle the head record is examined and either pushed back at the
// tail (kept, possibly refreshed, or replaced by a new record) or dropped.
// One item therefore takes a full rotation of the ring and then a hand-over
// of the result to the output register; the block accepts no new item until
// it has handed over the result and returned to idle.
// The result register lets the next item be accepted and processed while an
// earlier result is still waiting; if the receiver stalls for longer, the
// finished item waits in its final state until the register frees up.
// The configuration transfer (cfg_valid/cfg_ready, cfg_data) writes
// age_timeout and is always ready; write it only while the block is idle.
// Reset empties the table (count zero) and restores the default timeout.
`include "neighbor_table_with_aging_defines.svh"

module neighbor_table_with_aging #(
    parameter int unsigned MAX_ENTRIES = nta_pkg::MAX_ENTRIES_DEF,
    localparam int unsigned CW         = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [nta_pkg::TIME_W-1:0]         cfg_data,

    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               operation,
    input  logic [nta_pkg::ADDR_W-1:0]         node_addr,
    input  logic signed [nta_pkg::LEVEL_W-1:0] signal_level,
    input  logic [nta_pkg::TIME_W-1:0]         now_time,

    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [1:0]                         status,
    output logic [nta_pkg::CNT_OUT_W-1:0]      entry_count,
    output logic [nta_pkg::CNT_OUT_W-1:0]      removed_count
);

    localparam logic [CW-1:0] LAST_STEP = CW'(MAX_ENTRIES - 1);
    localparam logic [CW-1:0] FULL_LEN  = CW'(MAX_ENTRIES);

    // Control state.
    nta_pkg::fsm_t               state_reg, state_next;
    logic [CW-1:0]               count_reg, count_next;
    logic [CW-1:0]               step_reg, step_next;
    logic [CW-1:0]               len_reg, len_next;
    logic [CW-1:0]               removed_reg, removed_next;
    logic                        found_reg, found_next;
    logic                        ins_reg, ins_next;
    logic [nta_pkg::TIME_W-1:0]  timeout_reg;

    // The item being worked on.
    logic                               op_reg;
    logic [nta_pkg::ADDR_W-1:0]         addr_reg;
    logic signed [nta_pkg::LEVEL_W-1:0] level_reg;
    logic [nta_pkg::TIME_W-1:0]         now_reg;

    // Result register.
    logic                          out_valid_reg, out_valid_next;
    nta_pkg::status_t              status_reg, status_next;
    logic [nta_pkg::CNT_OUT_W-1:0] entry_count_reg;
    logic [nta_pkg::CNT_OUT_W-1:0] removed_count_reg;

    // FSM decodes.
    logic in_take;
    logic running;
    logic out_load;
    logic last_step;

    // Ring datapath.
    nta_pkg::cell_ctrl_t ctrl;
    nta_pkg::rec_t       head_rec;
    nta_pkg::rec_t       push_rec;
    logic                head_valid;
    logic                head_match;
    logic                head_insert;
    logic                head_aged;
    logic [nta_pkg::TIME_W-1:0] head_age;

    assign cfg_ready = 1'b1;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            nta_pkg::FSM_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = nta_pkg::FSM_RUN;
                end
            end
            nta_pkg::FSM_RUN:
            begin
                if (step_reg == LAST_STEP)
                begin
                    state_next = nta_pkg::FSM_DONE;
                end
            end
            nta_pkg::FSM_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = nta_pkg::FSM_IDLE;
                end
            end
            default:
            begin
                state_next = nta_pkg::FSM_IDLE;
            end
        endcase
    end

    // FSM outputs.
    always_comb
    begin
        in_ready  = 1'b0;
        running   = 1'b0;
        out_load  = 1'b0;
        last_step = 1'b0;
        unique case (state_reg)
            nta_pkg::FSM_IDLE:
            begin
                in_ready = 1'b1;
            end
            nta_pkg::FSM_RUN:
            begin
                running   = 1'b1;
                last_step = (step_reg == LAST_STEP);
            end
            nta_pkg::FSM_DONE:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign in_take = in_valid && in_ready;

    // Head of the ring: decide what, if anything, goes back in at the tail.
    assign head_valid  = (step_reg < count_reg);
    assign head_age    = now_reg - head_rec.seen;
    assign head_aged   = head_valid && (head_age > timeout_reg);
    assign head_match  = head_valid && !found_reg && (head_rec.addr == addr_reg);
    // The first free slot comes round only after every valid record has been
    // searched, so a miss is known by then.
    assign head_insert = !found_reg && (step_reg == count_reg);

    always_comb
    begin
        push_rec     = head_rec;
        ctrl.step    = running;
        ctrl.push    = 1'b1;
        found_next   = found_reg;
        ins_next     = ins_reg;
        removed_next = removed_reg;
        len_next     = len_reg;
        if (op_reg == nta_pkg::OP_SWEEP)
        begin
            if (head_aged)
            begin
                ctrl.push    = 1'b0;
                removed_next = removed_reg + CW'(1);
                len_next     = len_reg - CW'(1);
            end
        end
        else
        begin
            priority if (head_match)
            begin
                push_rec.level = level_reg;
                push_rec.seen  = now_reg;
                found_next     = 1'b1;
            end
            else if (head_insert)
            begin
                push_rec.addr  = addr_reg;
                push_rec.level = level_reg;
                push_rec.seen  = now_reg;
                ins_next       = 1'b1;
            end
        end
    end

    nta_row #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_row (
        .clk      (clk),
        .ctrl     (ctrl),
        .ring_len (len_reg),
        .push_rec (push_rec),
        .head_rec (head_rec)
    );

    // Count after the item, settled on the last rotation step.
    always_comb
    begin
        count_next = count_reg;
        if (last_step)
        begin
            if (op_reg == nta_pkg::OP_SWEEP)
            begin
                count_next = count_reg - removed_next;
            end
            else
            begin
                count_next = count_reg + CW'(ins_next);
            end
        end
    end

    assign step_next = in_take ? '0 : (running ? step_reg + CW'(1) : step_reg);

    always_comb
    begin
        if (op_reg == nta_pkg::OP_SWEEP)
        begin
            status_next = nta_pkg::STATUS_SWEPT;
        end
        else if (found_reg)
        begin
            status_next = nta_pkg::STATUS_REFRESHED;
        end
        else if (ins_reg)
        begin
            status_next = nta_pkg::STATUS_INSERTED;
        end
        else
        begin
            status_next = nta_pkg::STATUS_FULL;
        end
    end

    assign out_valid_next = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= nta_pkg::FSM_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            len_reg       <= FULL_LEN;
            removed_reg   <= '0;
            found_reg     <= 1'b0;
            ins_reg       <= 1'b0;
            timeout_reg   <= nta_pkg::AGE_TIMEOUT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                timeout_reg <= cfg_data;
            end
            if (in_take)
            begin
                len_reg     <= FULL_LEN;
                removed_reg <= '0;
                found_reg   <= 1'b0;
                ins_reg     <= 1'b0;
            end
            else if (running)
            begin
                len_reg     <= len_next;
                removed_reg <= removed_next;
                found_reg   <= found_next;
                ins_reg     <= ins_next;
            end
        end
    end

    // Item and result payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            op_reg    <= operation;
            addr_reg  <= node_addr;
            level_reg <= signal_level;
            now_reg   <= now_time;
        end
        if (out_load)
        begin
            status_reg        <= status_next;
            entry_count_reg   <= nta_pkg::CNT_OUT_W'(count_reg);
            removed_count_reg <= nta_pkg::CNT_OUT_W'(removed_reg);
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign entry_count   = entry_count_reg;
    assign removed_count = removed_count_reg;

    `NTA_NEVER(a_count_range, count_reg > FULL_LEN, "record count beyond table size")
    `NTA_ASSERT(a_run_ends, last_step |=> state_reg == nta_pkg::FSM_DONE, "rotation did not end")
    `NTA_ASSERT(a_seen_full_ring, (running && op_reg == nta_pkg::OP_SEEN) |-> len_reg == FULL_LEN, "ring shrank on a seen item")
    `NTA_NEVER(a_removed_bound, running && removed_reg > count_reg, "more records removed than held")

endmodule

// File: test/neighbor_table_with_aging_tb.sv
`timescale 1ns / 100ps

module neighbor_table_with_aging_tb;

    localparam int unsigned SLOTS = nta_pkg::MAX_ENTRIES_DEF;

    // One result transfer as the block should present it.
    typedef struct packed {
        nta_pkg::status_t              st;
        logic [nta_pkg::CNT_OUT_W-1:0] entries;
        logic [nta_pkg::CNT_OUT_W-1:0] removed;
    } neighbour_report_t;

    // The scoreboard keeps its own copy of the table and of age_timeout.
    // Every accepted item is run through that copy at once, and the outcome
    // is queued until the matching result transfer turns up. Signal levels
    // are never reported back, so only addresses and last-seen times are
    // kept here.
    class neighbour_scoreboard;
        logic [nta_pkg::ADDR_W-1:0] addr_tab [SLOTS];
        logic [nta_pkg::TIME_W-1:0] seen_tab [SLOTS];
        int unsigned                live_records;
        logic [nta_pkg::TIME_W-1:0] timeout;
        neighbour_report_t          pending_reports [$];
        int unsigned                errors;

        function new();
            live_records = 0;
            timeout      = nta_pkg::AGE_TIMEOUT_RESET;
            errors       = 0;
        endfunction

        // Applies one accepted item to the table copy and queues its result.
        function void record_item(logic op, logic [nta_pkg::ADDR_W-1:0] addr,
                                  logic [nta_pkg::TIME_W-1:0] now);
            neighbour_report_t rep;
            int unsigned       kept;
            int unsigned       dropped;
            bit                hit;
            begin
                hit     = 1'b0;
                dropped = 0;
                if (op == nta_pkg::OP_SWEEP)
                begin
                    // Survivors are packed towards the front in their old order.
                    kept = 0;
                    for (int i = 0; i < live_records; i++)
                    begin
                        if (nta_pkg::TIME_W'(now - seen_tab[i]) > timeout)
                        begin
                            dropped++;
                        end
                        else
                        begin
                            addr_tab[kept] = addr_tab[i];
                            seen_tab[kept] = seen_tab[i];
                            kept++;
                        end
                    end
                    live_records = kept;
                    rep.st = nta_pkg::STATUS_SWEPT;
                end
                else
                begin
                    for (int i = 0; i < live_records && !hit; i++)
                    begin
                        if (addr_tab[i] == addr)
                        begin
                            seen_tab[i] = now;
                            hit = 1'b1;
                        end
                    end
                    if (hit)
                    begin
                        rep.st = nta_pkg::STATUS_REFRESHED;
                    end
                    else if (live_records < SLOTS)
                    begin
                        addr_tab[live_records] = addr;
                        seen_tab[live_records] = now;
                        live_records++;
                        rep.st = nta_pkg::STATUS_INSERTED;
                    end
                    else
                    begin
                        rep.st = nta_pkg::STATUS_FULL;
                    end
                end
                rep.entries = nta_pkg::CNT_OUT_W'(live_records);
                rep.removed = nta_pkg::CNT_OUT_W'(dropped);
                pending_reports.push_back(rep);
            end
        endfunction

        // Compares one result transfer with the oldest queued outcome.
        // Mismatch lines give the expected value first, then the actual one.
        function void check_result(logic [1:0] st,
                                   logic [nta_pkg::CNT_OUT_W-1:0] entries,
                                   logic [nta_pkg::CNT_OUT_W-1:0] removed);
            neighbour_report_t want;
            begin
                if (pending_reports.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("tb: unexpected result status %0d entries %0d removed %0d",
                                 st, entries, removed);
                end
                else
                begin
                    want = pending_reports.pop_front();
                    if (want.st != st || want.entries != entries
                            || want.removed != removed)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("tb: mismatch status %0d/%0d entries %0d/%0d removed %0d/%0d",
                                     want.st, st, want.entries, entries,
                                     want.removed, removed);
                    end
                end
            end
        endfunction

        function int unsigned failures();
            return errors + pending_reports.size();
        endfunction
    endclass

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [nta_pkg::TIME_W-1:0]          cfg_data = '0;
    logic                                in_valid = 1'b0;
    logic                                in_ready;
    logic                                operation = nta_pkg::OP_SEEN;
    logic [nta_pkg::ADDR_W-1:0]          node_addr = '0;
    logic signed [nta_pkg::LEVEL_W-1:0]  signal_level = '0;
    logic [nta_pkg::TIME_W-1:0]          now_time = '0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic [1:0]                          status;
    logic [nta_pkg::CNT_OUT_W-1:0]       entry_count;
    logic [nta_pkg::CNT_OUT_W-1:0]       removed_count;

    // When clear, both sides run flat out with no gaps at all.
    bit                                  idle_on = 1'b1;

    neighbour_scoreboard                 predictor = new();

    neighbor_table_with_aging dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .node_addr     (node_addr),
        .signal_level  (signal_level),
        .now_time      (now_time),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .entry_count   (entry_count),
        .removed_count (removed_count)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Hard stop in case the block hangs; far beyond the slowest correct run.
    initial
    begin
        #(20_000_000);
        $display("tb: failure");
        $finish;
    end

    function automatic int draw_gap();
        return idle_on ? int'($urandom_range(0, 18)) : 0;
    endfunction

    // Presents one item after a random gap and holds it until the transfer.
    // Valid is only lowered when a gap is wanted, so back-to-back items
    // keep it high across the edge.
    task automatic send_item(logic op, logic [nta_pkg::ADDR_W-1:0] addr,
                             logic [nta_pkg::LEVEL_W-1:0] lvl,
                             logic [nta_pkg::TIME_W-1:0] now);
        int gap;
        begin
            gap = draw_gap();
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid     <= 1'b1;
            operation    <= op;
            node_addr    <= addr;
            signal_level <= lvl;
            now_time     <= now;
            do @(posedge clk); while (!in_ready);
            predictor.record_item(op, addr, now);
        end
    endtask

    // Withdraws the input and waits until every queued result has arrived,
    // then lets the block settle for a while before going on.
    task automatic drain_table();
        begin
            in_valid <= 1'b0;
            while (predictor.pending_reports.size() != 0) @(posedge clk);
            repeat (2 * (SLOTS + 2)) @(posedge clk);
        end
    endtask

    task automatic write_timeout(logic [nta_pkg::TIME_W-1:0] value);
        begin
            cfg_valid <= 1'b1;
            cfg_data  <= value;
            do @(posedge clk); while (!cfg_ready);
            cfg_valid <= 1'b0;
            predictor.timeout = value;
        end
    endtask

    // One phase of random traffic under a given timeout. Most items are
    // sightings from a small pool of neighbours with the tick moving steadily
    // forward, so the table fills, refreshes and ages as it would in use.
    // A few sweeps are mixed in, and now and then an item with a wholly
    // random address or tick acts as noise and forces wrapped ages.
    task automatic run_phase(logic [nta_pkg::TIME_W-1:0] timeout, int n_items,
                             bit with_gaps);
        logic [nta_pkg::ADDR_W-1:0] pool [32];
        int                         pool_size;
        logic [nta_pkg::TIME_W-1:0] tick;
        logic [nta_pkg::TIME_W-1:0] step_max;
        int                         pick;
        begin
            drain_table();
            write_timeout(timeout);
            idle_on   = with_gaps;
            pool_size = $urandom_range(4, 28);
            foreach (pool[i]) pool[i] = $urandom;
            if (timeout < 8)
                step_max = 3;
            else if (timeout > 32'h1000_0000)
                step_max = 32'h0400_0000;
            else
                step_max = timeout >> 2;
            tick = $urandom;
            repeat (n_items)
            begin
                pick = $urandom_range(0, 31);
                if (pick < 4)
                    send_item(nta_pkg::OP_SWEEP, $urandom,
                              nta_pkg::LEVEL_W'($urandom), tick);
                else if (pick == 4)
                    send_item(nta_pkg::OP_SEEN, $urandom,
                              nta_pkg::LEVEL_W'($urandom), $urandom);
                else if (pick == 5)
                    send_item(nta_pkg::OP_SWEEP, $urandom,
                              nta_pkg::LEVEL_W'($urandom), $urandom);
                else
                    send_item(nta_pkg::OP_SEEN, pool[$urandom_range(0, pool_size - 1)],
                              nta_pkg::LEVEL_W'($urandom), tick);
                tick += $urandom_range(0, step_max);
            end
        end
    endtask

    // Result side: draws a stall before each result, then takes whatever
    // comes and hands it to the scoreboard.
    initial
    begin : result_sink
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = draw_gap();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            predictor.check_result(status, entry_count, removed_count);
        end
    end

    initial
    begin : stimulus
        logic [nta_pkg::ADDR_W-1:0] fill_addr;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part, run with the timeout left at its reset value.
        // Field extremes first: lowest and highest address, level and tick.
        send_item(nta_pkg::OP_SEEN, 32'h0000_0000, 11'h400, 32'h0000_0000);
        send_item(nta_pkg::OP_SEEN, 32'hFFFF_FFFF, 11'h3FF, 32'hFFFF_FFFF);
        send_item(nta_pkg::OP_SEEN, 32'h0000_0000, 11'h000, 32'd5);
        // Age exactly at the timeout survives; the record heard at the top
        // of the tick range has wrapped and is just past it.
        send_item(nta_pkg::OP_SWEEP, 32'h0000_0000, 11'h000, 32'd120005);
        send_item(nta_pkg::OP_SWEEP, 32'hFFFF_FFFF, 11'h7FF, 32'd120006);
        // A sweep of an empty table.
        send_item(nta_pkg::OP_SWEEP, 32'h0000_0000, 11'h000, 32'd0);
        // Fill every slot, then offer one more neighbour while full.
        for (int i = 0; i < SLOTS; i++)
        begin
            fill_addr = 32'h0123_4567 * (i + 1);
            send_item(nta_pkg::OP_SEEN, fill_addr, nta_pkg::LEVEL_W'(i * 128),
                      nta_pkg::TIME_W'(i * 1000 + 100));
        end
        send_item(nta_pkg::OP_SEEN, 32'hA5A5_5A5A, 11'h155, 32'd20000);
        // Refreshing the last record must still work with the table full.
        send_item(nta_pkg::OP_SEEN, 32'h0123_4567 * SLOTS, 11'h2AA, 32'd16000);
        // A tick earlier than most last-seen times: those ages wrap to huge
        // values, so only the first record stays and the rest close up.
        send_item(nta_pkg::OP_SWEEP, 32'h0000_0000, 11'h000, 32'd500);

        // Random phases, each under a different timeout, extremes included.
        run_phase(32'd0,                      275, 1'b1);
        run_phase(32'hFFFF_FFFF,              275, 1'b1);
        run_phase(32'd1,                      275, 1'b0);
        run_phase($urandom_range(64, 4000),   275, 1'b1);
        run_phase(nta_pkg::AGE_TIMEOUT_RESET, 275, 1'b1);
        run_phase($urandom,                   275, 1'b0);

        idle_on = 1'b1;
        drain_table();
        if (predictor.failures() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
